[hdl/page_table_walker_assert.svh]
// ----------------------------------------------------------------------------
// Page table walker assertion macros
// Shared property forms for the walker's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PAGE_TABLE_WALKER_ASSERT_SVH
`define PAGE_TABLE_WALKER_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define PTW_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("page table walker check failed");

// Check that a condition implies another in the next cycle.
`define PTW_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("page table walker check failed");

`endif

[hdl/ptw_pkg.sv]
// ----------------------------------------------------------------------------
// Page table walker package
// Shared types, widths, register indexes and index/mask helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

    localparam int VA_W     = 57;
    localparam int PA_W     = 59;
    localparam int ENTRY_W  = 64;
    localparam int LEVEL_W  = 3;
    localparam int IDX_W    = 9;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 64;

    // Register index, taken from paddr bit 3 (8-byte spacing)
    localparam logic REG_LEVELS = 1'b0;
    localparam logic REG_ROOT   = 1'b1;

    localparam logic [LEVEL_W-1:0] LEVELS_MIN   = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVELS_MAX   = 3'd5;
    localparam logic [LEVEL_W-1:0] LEVELS_RESET = 3'd3;

    typedef enum logic [1:0] {
        KIND_READ     = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_UNMAPPED = 2'd2
    } kind_t;

    typedef struct packed {
        logic               busy;
        logic [LEVEL_W-1:0] level;
        logic [VA_W-1:0]    vaddr;
    } walk_state_t;

    typedef struct packed {
        kind_t              kind;
        logic [PA_W-1:0]    address;
        logic [LEVEL_W-1:0] page_level;
    } result_t;

    // Clamp the level count to the supported range
    function automatic logic [LEVEL_W-1:0] eff_levels(input logic [LEVEL_W-1:0] lv);
        logic [LEVEL_W-1:0] n;
        begin
            if (lv < LEVELS_MIN)
            begin
                n = LEVELS_MIN;
            end
            else if (lv > LEVELS_MAX)
            begin
                n = LEVELS_MAX;
            end
            else
            begin
                n = lv;
            end
            return n;
        end
    endfunction

    // Nine-bit table index of a virtual address at level 1..5
    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [LEVEL_W-1:0] lvl);
        logic [IDX_W-1:0] idx;
        begin
            unique case (lvl)
                3'd1:    idx = va[20:12];
                3'd2:    idx = va[29:21];
                3'd3:    idx = va[38:30];
                3'd4:    idx = va[47:39];
                3'd5:    idx = va[56:48];
                default: idx = '0;
            endcase
            return idx;
        end
    endfunction

    // Page offset mask for a leaf found at level 1..5
    function automatic logic [VA_W-1:0] offset_mask(input logic [LEVEL_W-1:0] lvl);
        logic [VA_W-1:0] m;
        begin
            unique case (lvl)
                3'd1:    m = 57'h0000_0000_0000_0FFF;
                3'd2:    m = 57'h0000_0000_001F_FFFF;
                3'd3:    m = 57'h0000_0000_3FFF_FFFF;
                3'd4:    m = 57'h0000_007F_FFFF_FFFF;
                3'd5:    m = 57'h0000_FFFF_FFFF_FFFF;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

    // Frame mask of an entry for a clamped level count
    function automatic logic [ENTRY_W-1:0] frame_mask(input logic [LEVEL_W-1:0] n);
        logic [ENTRY_W-1:0] m;
        begin
            unique case (n)
                3'd3:    m = 64'h0000_007F_FFFF_FC00;
                3'd4:    m = 64'h0000_FFFF_FFFF_FC00;
                default: m = 64'h01FF_FFFF_FFFF_FC00;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

[hdl/ptw_step.sv]
// ----------------------------------------------------------------------------
// Page table walker step
// Handles one beat: starts a walk or consumes one table entry, and forms
// the next walk state and the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptw_step (
    input  wire logic [ptw_pkg::LEVEL_W-1:0] levels,
    input  wire logic [ptw_pkg::PA_W-1:0]    root,
    input  wire logic                        mode,
    input  wire logic [ptw_pkg::VA_W-1:0]    virtual_address,
    input  wire logic [ptw_pkg::ENTRY_W-1:0] entry_data,
    input  wire ptw_pkg::walk_state_t        walk_cur,
    output ptw_pkg::walk_state_t             walk_nxt,
    output logic                             res_valid,
    output ptw_pkg::result_t                 res
);

    logic [ptw_pkg::LEVEL_W-1:0] n_eff;
    logic [ptw_pkg::ENTRY_W-1:0] masked;
    logic [ptw_pkg::PA_W-1:0]    frame;
    logic [ptw_pkg::LEVEL_W-1:0] lower_level;
    logic [ptw_pkg::PA_W-1:0]    root_off;
    logic [ptw_pkg::PA_W-1:0]    next_off;
    logic [ptw_pkg::VA_W-1:0]    page_off;
    logic                        level_ok;

    // Shared address pieces
    assign n_eff       = ptw_pkg::eff_levels(levels);
    assign masked      = entry_data & ptw_pkg::frame_mask(n_eff);
    assign frame       = {masked[ptw_pkg::PA_W-3:0], 2'b00};
    assign lower_level = walk_cur.level - 3'd1;
    assign root_off    = {47'd0, ptw_pkg::level_index(virtual_address, n_eff), 3'b000};
    assign next_off    = {47'd0, ptw_pkg::level_index(walk_cur.vaddr, lower_level), 3'b000};
    assign page_off    = walk_cur.vaddr & ptw_pkg::offset_mask(walk_cur.level);
    assign level_ok    = (walk_cur.level >= 3'd1) && (walk_cur.level <= ptw_pkg::LEVELS_MAX);

    // Decide the beat outcome
    always_comb
    begin
        walk_nxt       = walk_cur;
        res_valid      = 1'b0;
        res.kind       = ptw_pkg::KIND_READ;
        res.address    = '0;
        res.page_level = '0;

        if (!mode)
        begin
            // start a new walk, dropping any walk in flight
            walk_nxt.busy  = 1'b1;
            walk_nxt.level = n_eff;
            walk_nxt.vaddr = virtual_address;
            res_valid      = 1'b1;
            res.address    = root + root_off;
        end
        else if (walk_cur.busy && level_ok)
        begin
            res_valid = 1'b1;
            priority if (!entry_data[0])
            begin
                walk_nxt.busy  = 1'b0;
                walk_nxt.level = '0;
                res.kind       = ptw_pkg::KIND_UNMAPPED;
            end
            else if ((entry_data[3:1] != 3'b000) || (walk_cur.level == 3'd1))
            begin
                walk_nxt.busy  = 1'b0;
                walk_nxt.level = '0;
                res.kind       = ptw_pkg::KIND_DONE;
                res.address    = frame | {2'b00, page_off};
                res.page_level = lower_level;
            end
            else
            begin
                walk_nxt.level = lower_level;
                res.address    = frame + next_off;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/page_table_walker.sv]
// ----------------------------------------------------------------------------
// Page table walker
// Translates virtual addresses by walking a 3, 4 or 5 level radix table.
// ----------------------------------------------------------------------------
// Each beat (a translation request or a table entry returned by memory) is
// handled combinationally and its result beat appears in the output register
// on the following cycle, so the walker sustains one beat per clock. The only
// thing that stalls input is a full output register: in_ready drops only
// while a result beat is held and out_ready is low. A request issues a read
// of the root entry; each entry read back yields either the next entry read,
// a translation done beat with the physical address and page size code, or a
// not mapped beat. An entry beat arriving with no walk open gives no result.
// A new request abandons any walk in flight. Configure paging_levels (offset
// 0x0) and root_address (offset 0x8) only while the walker is idle.
`timescale 1ns / 1ps
`default_nettype none

`include "page_table_walker_assert.svh"

module page_table_walker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ptw_pkg::APB_AW-1:0]  paddr,
    input  wire logic [ptw_pkg::APB_DW-1:0]  pwdata,
    output logic      [ptw_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    // input beats
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        mode,
    input  wire logic [ptw_pkg::VA_W-1:0]    virtual_address,
    input  wire logic [ptw_pkg::ENTRY_W-1:0] entry_data,
    // result beats
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [1:0]                  kind,
    output logic      [ptw_pkg::PA_W-1:0]    address,
    output logic      [ptw_pkg::LEVEL_W-1:0] page_level
);

    logic [ptw_pkg::LEVEL_W-1:0] levels_reg;
    logic [ptw_pkg::PA_W-1:0]    root_reg;
    ptw_pkg::walk_state_t        walk_reg;
    ptw_pkg::walk_state_t        walk_next;
    ptw_pkg::result_t            out_reg;
    ptw_pkg::result_t            out_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        res_valid;
    logic                        in_fire;
    logic                        cfg_write;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= ptw_pkg::LEVELS_RESET;
            root_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3])
                ptw_pkg::REG_LEVELS: levels_reg <= pwdata[ptw_pkg::LEVEL_W-1:0];
                ptw_pkg::REG_ROOT:   root_reg   <= pwdata[ptw_pkg::PA_W-1:0];
                default:             root_reg   <= root_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            ptw_pkg::REG_LEVELS: prdata = {61'd0, levels_reg};
            ptw_pkg::REG_ROOT:   prdata = {5'd0, root_reg};
            default:             prdata = '0;
        endcase
    end

    // Accept a beat whenever the output register is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    ptw_step u_step (
        .levels          (levels_reg),
        .root            (root_reg),
        .mode            (mode),
        .virtual_address (virtual_address),
        .entry_data      (entry_data),
        .walk_cur        (walk_reg),
        .walk_nxt        (walk_next),
        .res_valid       (res_valid),
        .res             (out_next)
    );

    // Hold a result until taken; load a fresh one on accept
    assign out_valid_next = in_fire ? res_valid : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                walk_reg <= walk_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res_valid)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = out_reg.kind;
    assign address    = out_reg.address;
    assign page_level = out_reg.page_level;

    // An open walk always sits at a real table level
    `PTW_ASSERT_SAME(a_level_range, clk, rst_n, walk_reg.busy,
        (walk_reg.level >= 3'd1) && (walk_reg.level <= ptw_pkg::LEVELS_MAX))

    // A request beat opens a walk and issues an entry read
    `PTW_ASSERT_NEXT(a_request_reads, clk, rst_n, in_fire && !mode,
        out_valid_reg && walk_reg.busy && (out_reg.kind == ptw_pkg::KIND_READ))

    // A final result beat leaves the walker idle
    `PTW_ASSERT_SAME(a_final_idle, clk, rst_n,
        out_valid_reg && (out_reg.kind != ptw_pkg::KIND_READ), !walk_reg.busy)

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walker testbench
// Self-checking walks over 3, 4 and 5 level tables. Every accepted input
// beat runs through a local walk predictor. Each result beat is compared
// field by field with the oldest predicted result. The sender idles in
// bursts and the receiver stalls on its own pattern. Register writes happen
// between phases, once the walker has gone quiet.
// ----------------------------------------------------------------------------

module tb;

    localparam int CLK_HALF    = 4;
    localparam int RESET_CYC   = 11;
    localparam int CYCLE_LIMIT = 200000;
    localparam int QUIET_CYC   = 4;
    localparam int END_CYC     = 8;
    localparam int RANDOM_BEATS = 720;
    localparam int PHASES      = 6;
    localparam int LONG_HOLD   = 300;
    localparam int REPORT_MAX  = 10;

    localparam logic [ptw_pkg::APB_AW-1:0] ADDR_LEVELS = {ptw_pkg::REG_LEVELS, 3'b000};
    localparam logic [ptw_pkg::APB_AW-1:0] ADDR_ROOT   = {ptw_pkg::REG_ROOT, 3'b000};

    localparam logic        MODE_REQUEST  = 1'b0;
    localparam logic        MODE_RESPONSE = 1'b1;

    // DUT connections
    logic                            clk             = 1'b0;
    logic                            rst_n           = 1'b0;
    logic                            psel            = 1'b0;
    logic                            penable         = 1'b0;
    logic                            pwrite          = 1'b0;
    logic [ptw_pkg::APB_AW-1:0]      paddr           = '0;
    logic [ptw_pkg::APB_DW-1:0]      pwdata          = '0;
    logic [ptw_pkg::APB_DW-1:0]      prdata;
    logic                            pready;
    logic                            in_valid        = 1'b0;
    logic                            in_ready;
    logic                            mode            = 1'b0;
    logic [ptw_pkg::VA_W-1:0]        virtual_address = '0;
    logic [ptw_pkg::ENTRY_W-1:0]     entry_data      = '0;
    logic                            out_valid;
    logic                            out_ready       = 1'b0;
    logic [1:0]                      kind;
    logic [ptw_pkg::PA_W-1:0]        address;
    logic [ptw_pkg::LEVEL_W-1:0]     page_level;

    // Predictor copy of registers and walk state
    logic [ptw_pkg::LEVEL_W-1:0]     cfg_levels = ptw_pkg::LEVELS_RESET;
    logic [ptw_pkg::PA_W-1:0]        cfg_root   = '0;
    bit                              walk_open  = 1'b0;
    logic [ptw_pkg::LEVEL_W-1:0]     walk_depth = '0;
    logic [ptw_pkg::VA_W-1:0]        walk_vaddr = '0;

    ptw_pkg::result_t                pending_results[$];

    // Traffic shaping knobs
    int                   gap_pct       = 0;
    int                   burst_left    = 0;
    int                   stall_pct     = 0;
    int                   hold_request  = 0;
    int                   hold_left     = 0;
    int                   stall_left    = 0;

    // Bookkeeping
    int                   cycle_count   = 0;
    int                   fail_count    = 0;
    int                   beats_with_result = 0;
    int                   requests_sent = 0;
    int                   reads_seen    = 0;
    int                   unmapped_seen = 0;
    int                   done_seen[5];

    page_table_walker u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .virtual_address (virtual_address),
        .entry_data      (entry_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .address         (address),
        .page_level      (page_level)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Walk predictor
    // ------------------------------------------------------------------

    // Clamp the configured level count to 3..5
    function automatic logic [ptw_pkg::LEVEL_W-1:0] levels_in_use(
        input logic [ptw_pkg::LEVEL_W-1:0] lv);
        logic [ptw_pkg::LEVEL_W-1:0] n;
        begin
            n = lv;
            if (lv < 3'd3)
            begin
                n = 3'd3;
            end
            else if (lv > 3'd5)
            begin
                n = 3'd5;
            end
            return n;
        end
    endfunction

    // Pick the nine-bit table slot of a virtual address at one level
    function automatic logic [ptw_pkg::IDX_W-1:0] table_slot(
        input logic [ptw_pkg::VA_W-1:0] va, input logic [ptw_pkg::LEVEL_W-1:0] lvl);
        logic [ptw_pkg::VA_W-1:0] shifted;
        begin
            shifted = va >> (12 + 9 * (int'(lvl) - 1));
            return shifted[ptw_pkg::IDX_W-1:0];
        end
    endfunction

    // Advance the predicted walk by one beat; return 1 when a result is due
    function automatic bit walk_predict(input logic m, input logic [ptw_pkg::VA_W-1:0] va,
                                        input logic [ptw_pkg::ENTRY_W-1:0] e,
                                        output ptw_pkg::result_t r);
        logic [ptw_pkg::LEVEL_W-1:0] n;
        logic [63:0]                 fmask;
        logic [63:0]                 shifted;
        logic [63:0]                 offset;
        logic [ptw_pkg::PA_W-1:0]    frame;
        begin
            r.kind       = ptw_pkg::KIND_READ;
            r.address    = '0;
            r.page_level = '0;

            // Request: open a new walk at the top level
            if (m == MODE_REQUEST)
            begin
                n          = levels_in_use(cfg_levels);
                walk_vaddr = va;
                walk_depth = n;
                walk_open  = 1'b1;
                r.address  = cfg_root + {table_slot(va, n), 3'b000};
                return 1'b1;
            end

            // Drop responses with no walk open
            if (!walk_open)
            begin
                return 1'b0;
            end

            n       = levels_in_use(cfg_levels);
            fmask   = ((64'd1 << (9 * int'(n) + 12)) - 64'd1) & ~64'h3FF;
            shifted = (e & fmask) << 2;
            frame   = shifted[ptw_pkg::PA_W-1:0];

            if (!e[0])
            begin
                walk_open  = 1'b0;
                walk_depth = '0;
                r.kind     = ptw_pkg::KIND_UNMAPPED;
            end
            else if (e[3:1] != 3'b000 || walk_depth == 3'd1)
            begin
                offset       = (64'd1 << (12 + 9 * (int'(walk_depth) - 1))) - 64'd1;
                r.kind       = ptw_pkg::KIND_DONE;
                r.address    = frame | {2'b00, walk_vaddr & offset[ptw_pkg::VA_W-1:0]};
                r.page_level = walk_depth - 3'd1;
                walk_open    = 1'b0;
                walk_depth   = '0;
            end
            else
            begin
                walk_depth = walk_depth - 3'd1;
                r.address  = frame + {table_slot(walk_vaddr, walk_depth), 3'b000};
            end
            return 1'b1;
        end
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ptw_pkg::VA_W-1:0] rand_va();
        logic [63:0] v;
        begin
            v = {$urandom, $urandom};
            return v[ptw_pkg::VA_W-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // Failure log: report the first few, count the rest
    // ------------------------------------------------------------------
    task automatic log_failure(input string text);
        begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
            begin
                $display("%s", text);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: offer one input beat, hold it until accepted
    // ------------------------------------------------------------------
    task automatic offer_beat(input logic m, input logic [ptw_pkg::VA_W-1:0] va,
                              input logic [ptw_pkg::ENTRY_W-1:0] e);
        ptw_pkg::result_t r;
        begin
            // End a burst with a random gap now and then
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                if ($urandom_range(99) < gap_pct)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(negedge clk);
                end
            end
            burst_left--;

            in_valid        <= 1'b1;
            mode            <= m;
            virtual_address <= va;
            entry_data      <= e;

            do
            begin
                @(posedge clk);
            end
            while (!in_ready);

            if (m == MODE_REQUEST)
            begin
                requests_sent++;
            end
            if (walk_predict(m, va, e, r))
            begin
                pending_results.push_back(r);
                beats_with_result++;
            end
            @(negedge clk);
        end
    endtask

    // Hold off input until every predicted result has arrived, then settle
    task automatic wait_quiet();
        begin
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (QUIET_CYC) @(posedge clk);
            @(negedge clk);
        end
    endtask

    // APB write: setup cycle, then access cycle until pready, then idle
    task automatic write_reg(input logic [ptw_pkg::APB_AW-1:0] addr,
                             input logic [ptw_pkg::APB_DW-1:0] data);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= addr;
            pwdata  <= data;
            @(negedge clk);
            penable <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!pready);
            if (addr == ADDR_LEVELS)
            begin
                cfg_levels = data[ptw_pkg::LEVEL_W-1:0];
            end
            else
            begin
                cfg_root = data[ptw_pkg::PA_W-1:0];
            end
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Run one well-formed walk with random content and occasional aborts
    task automatic run_walk();
        int                          r;
        logic [ptw_pkg::ENTRY_W-1:0] e;
        logic [ptw_pkg::VA_W-1:0]    va;
        begin
            r  = $urandom_range(99);
            va = (r < 5) ? '0 : ((r < 10) ? '1 : rand_va());
            offer_beat(MODE_REQUEST, va, rand64());
            while (walk_open)
            begin
                r = $urandom_range(99);
                e = rand64();
                if (r < 4)
                begin
                    // Abandon the walk with a fresh request
                    offer_beat(MODE_REQUEST, rand_va(), e);
                end
                else
                begin
                    if (r < 16)
                    begin
                        e[0] = 1'b0;
                    end
                    else if (r < 36)
                    begin
                        e[0] = 1'b1;
                        if (e[3:1] == 3'b000)
                        begin
                            e[3:1] = 3'($urandom_range(1, 7));
                        end
                    end
                    else
                    begin
                        e[0]   = 1'b1;
                        e[3:1] = 3'b000;
                    end
                    offer_beat(MODE_RESPONSE, rand_va(), e);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls plus long hold-offs on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(99) < stall_pct)
        begin
            out_ready  <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each result beat with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        ptw_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                log_failure($sformatf("unexpected result beat: kind %0d address %h level %0d",
                                      kind, address, page_level));
            end
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind || address !== want.address ||
                    page_level !== want.page_level)
                begin
                    log_failure($sformatf(
                        {"mismatch: expected kind %0d address %h level %0d, ",
                         "got kind %0d address %h level %0d"},
                        want.kind, want.address, want.page_level, kind, address, page_level));
                end
                case (want.kind)
                    ptw_pkg::KIND_READ:     reads_seen++;
                    ptw_pkg::KIND_UNMAPPED: unmapped_seen++;
                    default:                done_seen[want.page_level]++;
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("page_table_walker regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Basic walks on the reset configuration
    task automatic test_walk_basics();
        begin
            gap_pct   = 0;
            stall_pct = 0;
            // Response with no walk open: ignored
            offer_beat(MODE_RESPONSE, '0, rand64());
            // Leaf at the top level with every entry bit set
            offer_beat(MODE_REQUEST, '0, '0);
            offer_beat(MODE_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFF);
            // Full descent on an all-ones address, leaf by reaching level 1
            offer_beat(MODE_REQUEST, '1, '1);
            offer_beat(MODE_RESPONSE, '1, 64'hFFFF_FFFF_FFFF_FFF1);
            offer_beat(MODE_RESPONSE, '1, 64'hFFFF_FFFF_FFFF_FFF1);
            offer_beat(MODE_RESPONSE, '1, 64'hFFFF_FFFF_FFFF_FFF1);
            // Cleared valid bit ends the walk as not mapped
            offer_beat(MODE_REQUEST, rand_va(), '0);
            offer_beat(MODE_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFE);
            // Request during a walk drops the old walk
            offer_beat(MODE_REQUEST, rand_va(), '0);
            offer_beat(MODE_REQUEST, rand_va(), '0);
            offer_beat(MODE_RESPONSE, '0, 64'h0000_0000_0000_0003);
            // Response after the walk closed: ignored
            offer_beat(MODE_RESPONSE, '0, 64'h0000_0000_0000_0001);
            wait_quiet();
        end
    endtask

    // Level counts in and out of range, root extremes, change mid-walk
    task automatic test_level_settings();
        begin
            // Five levels, unaligned all-ones root wraps the entry address
            write_reg(ADDR_LEVELS, 64'd5);
            write_reg(ADDR_ROOT, {{(ptw_pkg::APB_DW-ptw_pkg::PA_W){1'b0}},
                                  {ptw_pkg::PA_W{1'b1}}});
            offer_beat(MODE_REQUEST, '1, '0);
            offer_beat(MODE_RESPONSE, '0, 64'h01FF_FFFF_FFFF_FC01);
            offer_beat(MODE_RESPONSE, '0, 64'h01FF_FFFF_FFFF_FC01);
            offer_beat(MODE_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFF);
            wait_quiet();

            // Level count below range acts as three
            write_reg(ADDR_LEVELS, 64'd0);
            write_reg(ADDR_ROOT, '0);
            offer_beat(MODE_REQUEST, rand_va(), '0);
            offer_beat(MODE_RESPONSE, '0, rand64() | 64'h5);
            wait_quiet();

            // Level count above range acts as five: 256T leaf
            write_reg(ADDR_LEVELS, 64'd7);
            offer_beat(MODE_REQUEST, rand_va(), '0);
            offer_beat(MODE_RESPONSE, '0, rand64() | 64'h9);
            wait_quiet();

            // Four levels: 512G leaf
            write_reg(ADDR_LEVELS, 64'd4);
            offer_beat(MODE_REQUEST, rand_va(), '0);
            offer_beat(MODE_RESPONSE, '0, rand64() | 64'h3);
            wait_quiet();

            // Level count changed with a walk open: depth stays, mask follows
            write_reg(ADDR_LEVELS, 64'd5);
            offer_beat(MODE_REQUEST, rand_va(), '0);
            wait_quiet();
            write_reg(ADDR_LEVELS, 64'd3);
            offer_beat(MODE_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFF1);
            offer_beat(MODE_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFF3);
            wait_quiet();
        end
    endtask

    // Long receiver hold-off while the sender keeps offering beats
    task automatic test_backpressure();
        int start_count;
        begin
            gap_pct      = 0;
            stall_pct    = 0;
            start_count  = beats_with_result;
            hold_request = LONG_HOLD;
            while (beats_with_result - start_count < 40)
            begin
                run_walk();
            end
            wait_quiet();
        end
    endtask

    // Random walks over several register settings and traffic patterns
    task automatic test_random_walks();
        int                         phase;
        int                         start_count;
        logic [ptw_pkg::APB_DW-1:0] root;
        begin
            for (phase = 0; phase < PHASES; phase++)
            begin
                wait_quiet();
                root = rand64();
                case (phase)
                    0:
                    begin
                        write_reg(ADDR_LEVELS, 64'd3);
                        root[11:0] = '0;
                        gap_pct    = 0;
                        stall_pct  = 0;
                    end
                    1:
                    begin
                        write_reg(ADDR_LEVELS, 64'd4);
                        root       = '0;
                        gap_pct    = 30;
                        stall_pct  = 30;
                    end
                    2:
                    begin
                        write_reg(ADDR_LEVELS, 64'd5);
                        root       = {{(ptw_pkg::APB_DW-ptw_pkg::PA_W){1'b0}},
                                      {ptw_pkg::PA_W{1'b1}}};
                        gap_pct    = 60;
                        stall_pct  = 10;
                    end
                    3:
                    begin
                        write_reg(ADDR_LEVELS, 64'($urandom_range(0, 7)));
                        gap_pct    = 10;
                        stall_pct  = 60;
                    end
                    4:
                    begin
                        write_reg(ADDR_LEVELS, 64'd5);
                        gap_pct    = 50;
                        stall_pct  = 50;
                    end
                    default:
                    begin
                        write_reg(ADDR_LEVELS, 64'd3);
                        gap_pct    = 0;
                        stall_pct  = 20;
                    end
                endcase
                write_reg(ADDR_ROOT, root);

                start_count = beats_with_result;
                while (beats_with_result - start_count < RANDOM_BEATS / PHASES)
                begin
                    case ($urandom_range(99))
                        0, 1, 2, 3, 4:
                        begin
                            // Stray response between walks
                            offer_beat(MODE_RESPONSE, rand_va(), rand64());
                        end
                        5, 6:
                        begin
                            // Fully random beat
                            offer_beat(1'($urandom_range(0, 1)), rand_va(), rand64());
                        end
                        7:
                        begin
                            // Pause the sender until the walker drains
                            wait_quiet();
                        end
                        default:
                        begin
                            run_walk();
                        end
                    endcase
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYC) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_walk_basics();
        test_level_settings();
        test_backpressure();
        test_random_walks();

        // Drain and let the last beats settle
        wait_quiet();
        repeat (END_CYC) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            log_failure($sformatf("%0d predicted results never arrived",
                                  pending_results.size()));
        end

        $display("covered %0d requests: %0d entry reads, %0d not mapped, %0d mismatches",
                 requests_sent, reads_seen, unmapped_seen, fail_count);
        $display("translations by page size 4K/2M/1G/512G/256T: %0d/%0d/%0d/%0d/%0d",
                 done_seen[0], done_seen[1], done_seen[2], done_seen[3], done_seen[4]);
        if (fail_count == 0)
        begin
            $display("page_table_walker regression: pass");
        end
        else
        begin
            $display("page_table_walker regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/ptw_pkg.sv
hdl/ptw_step.sv
hdl/page_table_walker.sv
verif/tb.sv
